FILE: design/text_mode_row_renderer_unit_macros.svh
// ----------------------------------------------------------------------------
// Text mode row renderer: assertion macros
// Concurrent checks for simulation. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef TEXT_MODE_ROW_RENDERER_UNIT_MACROS_SVH
`define TEXT_MODE_ROW_RENDERER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TMRR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: check failed");
`define TMRR_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) pre |=> post) \
      else $error("%m: check failed");
`else
`define TMRR_ASSERT(label, clk, rst, prop)
`define TMRR_ASSERT_NEXT(label, clk, rst, pre, post)
`endif
`endif

FILE: design/tmrr_pkg.sv
// ----------------------------------------------------------------------------
// Text mode row renderer: shared package
// Geometry constants, codes, beat and control types, and the 5x7 font.
// ----------------------------------------------------------------------------
`default_nettype none

package tmrr_pkg;

   localparam int WIDTH       = 200;
   localparam int BAND_HEIGHT = 25;
   localparam int TEXT_LINES  = 8;
   localparam int LINE_CHARS  = 32;
   localparam int CHAR_PITCH  = 12;
   localparam int SCALE       = 2;

   localparam int ROW_BYTES   = (WIDTH + 7) / 8;
   localparam int PIX_TOTAL   = ROW_BYTES * 8;
   localparam int STORE_SIZE  = TEXT_LINES * LINE_CHARS;
   localparam int STORE_AW    = $clog2(STORE_SIZE);
   localparam int LINE_AW     = (TEXT_LINES > 1) ? $clog2(TEXT_LINES) : 1;
   localparam int COL_AW      = $clog2(LINE_CHARS);

   localparam int COORD_W     = 8;
   localparam int PX_W        = 8;
   localparam int BYTE_IDX_W  = 5;
   localparam int PADDR_W     = 4;

   localparam int INBAND_W    = $clog2(BAND_HEIGHT);
   localparam int INCELL_W    = $clog2(CHAR_PITCH);
   localparam int TROW_W      = $clog2(7 * SCALE);
   localparam int DIV_IN_W    = 5;

   localparam int RECIP_SHIFT  = 16;
   localparam int RECIP_W      = 17;
   localparam int BAND_RECIP   = ((1 << RECIP_SHIFT) + BAND_HEIGHT - 1) / BAND_HEIGHT;
   localparam int PITCH_RECIP  = ((1 << RECIP_SHIFT) + CHAR_PITCH - 1) / CHAR_PITCH;
   localparam int SCALE_RECIP  = ((1 << RECIP_SHIFT) + SCALE - 1) / SCALE;
   localparam int PROD_W       = COORD_W + RECIP_W;
   localparam int SCALE_PROD_W = DIV_IN_W + RECIP_W;

   localparam logic [7:0] CODE_FIRST  = 8'd32;
   localparam logic [7:0] CODE_LAST   = 8'd127;
   localparam int         GLYPH_IDX_W = 7;
   localparam int         GLYPH_COUNT = 96;

   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_CLEAR  = 2'd1;
   localparam logic [1:0] FUNC_RENDER = 2'd2;

   localparam logic [1:0] ROT_UPRIGHT = 2'd0;
   localparam logic [1:0] ROT_CW      = 2'd1;

   localparam logic [1:0] REG_ROTATION    = 2'd0;
   localparam logic [1:0] REG_MARGIN_TOP  = 2'd1;
   localparam logic [1:0] REG_MARGIN_LEFT = 2'd2;

   localparam logic [1:0] RESET_ROTATION    = 2'd0;
   localparam logic [4:0] RESET_MARGIN_TOP  = 5'd5;
   localparam logic [7:0] RESET_MARGIN_LEFT = 8'd4;

   typedef struct packed {
      logic [1:0] func;
      logic [2:0] line;
      logic [4:0] column;
      logic [7:0] char_code;
      logic [7:0] row;
   } req_type;

   typedef struct packed {
      logic [7:0] pixel_byte;
      logic [4:0] byte_index;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] rotation;
      logic [4:0] margin_top;
      logic [7:0] margin_left;
   } cfg_type;

   typedef struct packed {
      logic            write;
      logic            clear;
      logic            start;
      logic            issue;
      logic [PX_W-1:0] px;
   } ctl_cmd_type;

   typedef struct packed {
      logic adv;
      logic busy;
   } dp_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } ctl_state_type;

   localparam logic [39:0] GLYPH_ROM [GLYPH_COUNT] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h0609090600, 40'h0000000000
   };

endpackage

`default_nettype wire

FILE: design/text_mode_row_renderer_unit.sv
// ----------------------------------------------------------------------------
// Text mode row renderer: top level
// Character generator for a 1-bit panel: a line store of character codes,
// a 5x7 font scaled and placed by margins, and a row render that streams
// packed pixel bytes (MSB leftmost, 1 white).
//
// Request beats (req_*) write one character, clear the store, or ask for one
// physical pixel row. A row request walks its pixels one per cycle while the
// receiver does not stall, through one store lookup and one font lookup, and
// packs PIX_TOTAL pixels (200) into bytes; a byte is sent for every eight
// pixels of the row.
// Result beats (rsp_*) carry pixel_byte, byte_index and last on the final
// byte. A stalled receiver freezes the pixel pipeline behind the output
// register; the next request is taken once the pipeline is empty, even while
// the final byte still waits. Reset empties every line at once (per-entry
// flags) and loads rotation 0, top margin 5, left margin 4. The APB-style
// port holds the three registers at byte offsets 0, 4 and 8.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_row_renderer_unit (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  tmrr_pkg::req_type            req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output tmrr_pkg::rsp_type            rsp_payload,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tmrr_pkg::PADDR_W-1:0] paddr,
   input  logic [31:0]                  pwdata,
   output logic [31:0]                  prdata,
   output logic                         pready
);
   import tmrr_pkg::*;

   cfg_type       cfg;
   ctl_cmd_type   cmd;
   dp_status_type status;

   tmrr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   tmrr_ctl u_ctl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .req_stall   (req_stall),
      .cmd         (cmd),
      .status      (status)
   );

   tmrr_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_payload (req_payload),
      .cfg         (cfg),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

FILE: design/tmrr_csr.sv
// ----------------------------------------------------------------------------
// Text mode row renderer: configuration registers
// APB-style register file for rotation and the two margins.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrr_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [tmrr_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready,
   output tmrr_pkg::cfg_type             cfg
);
   import tmrr_pkg::*;

   logic [1:0] rotation_ff;
   logic [4:0] margin_top_ff;
   logic [7:0] margin_left_ff;
   logic       write_en;
   logic [1:0] reg_idx;

   assign write_en = psel && penable && pwrite;
   assign reg_idx  = paddr[PADDR_W-1:2];
   assign pready   = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_ff    <= RESET_ROTATION;
         margin_top_ff  <= RESET_MARGIN_TOP;
         margin_left_ff <= RESET_MARGIN_LEFT;
      end else if (write_en) begin
         unique case (reg_idx)
            REG_ROTATION:    rotation_ff    <= pwdata[1:0];
            REG_MARGIN_TOP:  margin_top_ff  <= pwdata[4:0];
            REG_MARGIN_LEFT: margin_left_ff <= pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_ROTATION:    prdata = 32'(rotation_ff);
         REG_MARGIN_TOP:  prdata = 32'(margin_top_ff);
         REG_MARGIN_LEFT: prdata = 32'(margin_left_ff);
         default:         prdata = '0;
      endcase
   end

   assign cfg = '{rotation: rotation_ff, margin_top: margin_top_ff,
                  margin_left: margin_left_ff};

endmodule

`default_nettype wire

FILE: design/tmrr_ctl.sv
// ----------------------------------------------------------------------------
// Text mode row renderer: controller
// Decodes request beats and sequences the pixel index through a row.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrr_ctl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  tmrr_pkg::req_type       req_payload,
   output logic                    req_stall,
   output tmrr_pkg::ctl_cmd_type   cmd,
   input  tmrr_pkg::dp_status_type status
);
   import tmrr_pkg::*;

`include "text_mode_row_renderer_unit_macros.svh"

   ctl_state_type   state_ff, state_in;
   logic [PX_W-1:0] px_ff, px_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         px_ff    <= '0;
      end else begin
         state_ff <= state_in;
         px_ff    <= px_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      px_in    = px_ff;
      cmd      = '0;
      cmd.px   = px_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_payload.func)
                  FUNC_WRITE: cmd.write = 1'b1;
                  FUNC_CLEAR: cmd.clear = 1'b1;
                  FUNC_RENDER: begin
                     cmd.start = 1'b1;
                     px_in     = '0;
                     state_in  = ST_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_RUN: begin
            if (status.adv) begin
               cmd.issue = 1'b1;
               if (px_ff == PX_W'(PIX_TOTAL - 1)) begin
                  state_in = ST_DRAIN;
               end else begin
                  px_in = px_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (!status.busy) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_stall = (state_ff != ST_IDLE);

   `TMRR_ASSERT(a_idle_empty, clock, reset, (state_ff == ST_IDLE) |-> !status.busy)
   `TMRR_ASSERT(a_issue_run, clock, reset, cmd.issue |-> (state_ff == ST_RUN && status.adv))

endmodule

`default_nettype wire

FILE: design/tmrr_dp.sv
// ----------------------------------------------------------------------------
// Text mode row renderer: datapath
// Line store, pixel pipeline (coordinates, store lookup, glyph), byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrr_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  tmrr_pkg::ctl_cmd_type   cmd,
   output tmrr_pkg::dp_status_type status,
   input  tmrr_pkg::req_type       req_payload,
   input  tmrr_pkg::cfg_type       cfg,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output tmrr_pkg::rsp_type       rsp_payload
);
   import tmrr_pkg::*;

`include "text_mode_row_renderer_unit_macros.svh"

   logic                    adv;
   logic [COORD_W-1:0]      row_ff;
   logic [LINE_CHARS-1:0]   nz_ff [TEXT_LINES];
   logic [7:0]              store_mem [STORE_SIZE];
   logic                    store_we;
   logic [STORE_AW-1:0]     waddr;
   logic [STORE_AW-1:0]     raddr;

   logic                    pix_blank;
   logic [COORD_W-1:0]      lx;
   logic [COORD_W-1:0]      ly;
   logic [COORD_W:0]        cx_ext;
   logic [PROD_W-1:0]       ly_prod;
   logic [PROD_W-1:0]       cx_prod;

   logic                    s1_valid_ff;
   logic                    s1_blank_ff;
   logic [COORD_W-1:0]      s1_ly_ff;
   logic [COORD_W-1:0]      s1_band_ff;
   logic [COORD_W-1:0]      s1_cx_ff;
   logic [COORD_W-1:0]      s1_cell_ff;
   logic                    s1_end_ff;
   logic                    s1_last_ff;
   logic [BYTE_IDX_W-1:0]   s1_idx_ff;

   logic [COORD_W-1:0]      band_base;
   logic [COORD_W-1:0]      cell_base;
   logic [INBAND_W-1:0]     inband;
   logic [INBAND_W-1:0]     trow_full;
   logic [INCELL_W-1:0]     incell;
   logic                    band_ok;
   logic                    trow_ok;
   logic                    cell_ok;
   logic                    shown_ok;
   logic [LINE_AW-1:0]      line_sel;
   logic [LINE_CHARS-1:0]   nz_row;
   logic                    s2_blank_in;

   logic                    s2_valid_ff;
   logic                    s2_blank_ff;
   logic [TROW_W-1:0]       s2_trow_ff;
   logic [INCELL_W-1:0]     s2_incell_ff;
   logic                    s2_end_ff;
   logic                    s2_last_ff;
   logic [BYTE_IDX_W-1:0]   s2_idx_ff;
   logic [7:0]              code_ff;

   logic                    code_ok;
   logic                    incell_ok;
   logic [SCALE_PROD_W-1:0] col_prod;
   logic [SCALE_PROD_W-1:0] trowq_prod;
   logic [2:0]              col;
   logic [2:0]              trowq;
   logic [GLYPH_IDX_W-1:0]  glyph_idx;
   logic [39:0]             glyph;
   logic [7:0]              colbyte;
   logic                    white;

   logic [6:0]              acc_ff;
   logic                    rsp_valid_ff;
   rsp_type                 rsp_payload_ff;
   logic                    out_load;

   assign adv         = !rsp_valid_ff || !rsp_stall;
   assign status.adv  = adv;
   assign status.busy = s1_valid_ff || s2_valid_ff;

   // line store
   assign store_we = cmd.write && (req_payload.line < TEXT_LINES)
                     && (req_payload.column < LINE_CHARS - 1);
   assign waddr    = STORE_AW'(req_payload.line * LINE_CHARS + req_payload.column);

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         for (int i = 0; i < TEXT_LINES; i++) begin
            nz_ff[i] <= '0;
         end
      end else if (store_we) begin
         nz_ff[req_payload.line][req_payload.column] <= (req_payload.char_code != 8'd0);
      end
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[waddr] <= req_payload.char_code;
      end
      if (adv) begin
         code_ff <= store_mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         row_ff <= req_payload.row;
      end
   end

   // stage 1: logical coordinates and quotients
   always_comb begin
      pix_blank = (row_ff >= WIDTH) || (cmd.px >= WIDTH);
      unique case (cfg.rotation)
         ROT_UPRIGHT: begin
            lx = COORD_W'(cmd.px);
            ly = row_ff;
         end
         ROT_CW: begin
            lx = row_ff;
            ly = COORD_W'(WIDTH - 1) - COORD_W'(cmd.px);
         end
         default: begin
            lx = COORD_W'(WIDTH - 1) - row_ff;
            ly = COORD_W'(cmd.px);
         end
      endcase
      cx_ext  = (COORD_W + 1)'(lx) - (COORD_W + 1)'(cfg.margin_left);
      ly_prod = PROD_W'(ly) * PROD_W'(BAND_RECIP);
      cx_prod = PROD_W'(cx_ext[COORD_W-1:0]) * PROD_W'(PITCH_RECIP);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= cmd.issue;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_blank_ff <= pix_blank || cx_ext[COORD_W];
         s1_ly_ff    <= ly;
         s1_band_ff  <= ly_prod[RECIP_SHIFT +: COORD_W];
         s1_cx_ff    <= cx_ext[COORD_W-1:0];
         s1_cell_ff  <= cx_prod[RECIP_SHIFT +: COORD_W];
         s1_end_ff   <= &cmd.px[2:0];
         s1_last_ff  <= (cmd.px == PX_W'(PIX_TOTAL - 1));
         s1_idx_ff   <= BYTE_IDX_W'(cmd.px[PX_W-1:3]);
      end
   end

   // stage 2: band and cell checks, store read
   always_comb begin
      band_base = COORD_W'(s1_band_ff * BAND_HEIGHT);
      cell_base = COORD_W'(s1_cell_ff * CHAR_PITCH);
      inband    = INBAND_W'(s1_ly_ff - band_base);
      incell    = INCELL_W'(s1_cx_ff - cell_base);
      band_ok   = (s1_band_ff < TEXT_LINES);
      trow_full = inband - INBAND_W'(cfg.margin_top);
      trow_ok   = (inband >= cfg.margin_top) && (trow_full < 7 * SCALE);
      cell_ok   = (s1_cell_ff < LINE_CHARS - 1);
      line_sel  = s1_band_ff[LINE_AW-1:0];
      nz_row    = nz_ff[line_sel];
      shown_ok  = 1'b1;
      for (int j = 0; j < LINE_CHARS - 1; j++) begin
         if ((COORD_W'(j) <= s1_cell_ff) && !nz_row[j]) begin
            shown_ok = 1'b0;
         end
      end
      raddr       = STORE_AW'(line_sel * LINE_CHARS + s1_cell_ff[COL_AW-1:0]);
      s2_blank_in = s1_blank_ff || !band_ok || !trow_ok || !cell_ok || !shown_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_blank_ff  <= s2_blank_in;
         s2_trow_ff   <= TROW_W'(trow_full);
         s2_incell_ff <= incell;
         s2_end_ff    <= s1_end_ff;
         s2_last_ff   <= s1_last_ff;
         s2_idx_ff    <= s1_idx_ff;
      end
   end

   // stage 3: glyph lookup
   always_comb begin
      code_ok    = (code_ff >= CODE_FIRST) && (code_ff <= CODE_LAST);
      incell_ok  = (s2_incell_ff < 5 * SCALE);
      col_prod   = SCALE_PROD_W'(s2_incell_ff) * SCALE_PROD_W'(SCALE_RECIP);
      trowq_prod = SCALE_PROD_W'(s2_trow_ff) * SCALE_PROD_W'(SCALE_RECIP);
      col        = col_prod[RECIP_SHIFT +: 3];
      trowq      = trowq_prod[RECIP_SHIFT +: 3];
      glyph_idx  = GLYPH_IDX_W'(code_ff - CODE_FIRST);
      glyph      = code_ok ? GLYPH_ROM[glyph_idx] : '0;
      unique case (col)
         3'd0:    colbyte = glyph[39:32];
         3'd1:    colbyte = glyph[31:24];
         3'd2:    colbyte = glyph[23:16];
         3'd3:    colbyte = glyph[15:8];
         3'd4:    colbyte = glyph[7:0];
         default: colbyte = '0;
      endcase
      white = s2_blank_ff || !code_ok || !incell_ok || !colbyte[trowq];
   end

   // byte packer and output register
   assign out_load = adv && s2_valid_ff && s2_end_ff;

   always_ff @(posedge clock) begin
      if (adv && s2_valid_ff) begin
         acc_ff <= {acc_ff[5:0], white};
      end
      if (out_load) begin
         rsp_payload_ff <= '{pixel_byte: {acc_ff, white}, byte_index: s2_idx_ff,
                             last: s2_last_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `TMRR_ASSERT(a_store_quiet, clock, reset, (cmd.write || cmd.clear) |-> !status.busy)
   `TMRR_ASSERT(a_last_index, clock, reset, (rsp_valid_ff && rsp_payload_ff.last) |-> (rsp_payload_ff.byte_index == BYTE_IDX_W'(ROW_BYTES - 1)))

endmodule

`default_nettype wire

FILE: verif/text_mode_row_renderer_unit_test.sv
// ----------------------------------------------------------------------------
// Text mode row renderer: unit testbench
// Drives character writes, clears and row requests through the request
// channel, sets rotation and margins through the register port between
// phases, and checks every pixel byte against an in-bench model of the line
// store, font lookup, margins and rotation. A short scripted part covers
// field extremes and corner cases, then random traffic runs under several
// idle and stall mixes.
// ----------------------------------------------------------------------------
`default_nettype none

module text_mode_row_renderer_unit_test;
   import tmrr_pkg::*;

   localparam logic [1:0] FUNC_NONE   = 2'd3;
   localparam int         CYCLE_LIMIT = 1000000;
   localparam int         DRAIN_WAIT  = 24;

   localparam logic [39:0] FONT_5X7 [96] = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
      40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
      40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
      40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
      40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
      40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
      40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
      40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
      40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h0C5252523E,
      40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
      40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420,
      40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
      40'h4428102844, 40'h0C5050503C, 40'h4464544C44, 40'h0008364100,
      40'h00007F0000, 40'h0041360800, 40'h0609090600, 40'h0000000000
   };

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_type           req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_type           rsp_payload;
   logic              psel        = 1'b0;
   logic              penable     = 1'b0;
   logic              pwrite      = 1'b0;
   logic [PADDR_W-1:0] paddr      = '0;
   logic [31:0]       pwdata      = '0;
   logic [31:0]       prdata;
   logic              pready;

   logic [7:0]        shadow_text [TEXT_LINES][LINE_CHARS];
   cfg_type           shadow_cfg;
   rsp_type           expected_bytes [$];
   req_type           script_items [$];
   bit                script_white [$];
   int                mismatches    = 0;
   int                send_idle_pct = 0;
   int                stall_pct     = 0;

   text_mode_row_renderer_unit uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL text_mode_row_renderer_unit");
      $finish;
   end

   task automatic note_mismatch(string what, int got, int want);
      mismatches++;
      if (mismatches <= 40)
         $display("mismatch %s: got %0h want %0h", what, got, want);
   endtask

   function automatic int shown_chars(int ln);
      int n;
      n = 0;
      while (n < LINE_CHARS - 1 && shadow_text[ln][n] != 8'd0) n++;
      return n;
   endfunction

   function automatic bit pixel_dark(int lx, int ly);
      int band, inband, trow, cx, cell_idx, incell, code, col;
      logic [7:0] glyph_col;
      band   = ly / BAND_HEIGHT;
      inband = ly % BAND_HEIGHT;
      if (band >= TEXT_LINES) return 1'b0;
      if (inband < int'(shadow_cfg.margin_top)) return 1'b0;
      trow = inband - int'(shadow_cfg.margin_top);
      if (trow >= 7 * SCALE) return 1'b0;
      if (lx < int'(shadow_cfg.margin_left)) return 1'b0;
      cx       = lx - int'(shadow_cfg.margin_left);
      cell_idx = cx / CHAR_PITCH;
      incell   = cx % CHAR_PITCH;
      if (cell_idx >= shown_chars(band)) return 1'b0;
      code = int'(shadow_text[band][cell_idx]);
      if (code < 32 || code > 127) return 1'b0;
      if (incell >= 5 * SCALE) return 1'b0;
      col       = incell / SCALE;
      glyph_col = FONT_5X7[code - 32][39 - 8 * col -: 8];
      return glyph_col[trow / SCALE];
   endfunction

   function automatic void predict_row(int r, bit all_white);
      rsp_type beat;
      int px, lx, ly;
      for (int k = 0; k < ROW_BYTES; k++) begin
         beat.pixel_byte = 8'hFF;
         beat.byte_index = k[4:0];
         beat.last       = (k == ROW_BYTES - 1);
         for (int b = 0; b < 8; b++) begin
            px = k * 8 + b;
            if (all_white || r >= WIDTH || px >= WIDTH) continue;
            case (shadow_cfg.rotation)
               ROT_UPRIGHT: begin
                  lx = px;
                  ly = r;
               end
               ROT_CW: begin
                  lx = r;
                  ly = WIDTH - 1 - px;
               end
               default: begin
                  lx = WIDTH - 1 - r;
                  ly = px;
               end
            endcase
            if (pixel_dark(lx, ly)) beat.pixel_byte[7 - b] = 1'b0;
         end
         expected_bytes.push_back(beat);
      end
   endfunction

   function automatic void apply_item(req_type it, bit all_white);
      case (it.func)
         FUNC_WRITE: begin
            if (it.line < TEXT_LINES && it.column < LINE_CHARS - 1)
               shadow_text[it.line][it.column] = it.char_code;
         end
         FUNC_CLEAR: begin
            foreach (shadow_text[i, j]) shadow_text[i][j] = 8'd0;
         end
         FUNC_RENDER: predict_row(int'(it.row), all_white);
         default: ;
      endcase
   endfunction

   function automatic req_type make_item(logic [1:0] f, int ln, int cl, int ch, int rw);
      req_type it;
      it.func      = f;
      it.line      = ln[2:0];
      it.column    = cl[4:0];
      it.char_code = ch[7:0];
      it.row       = rw[7:0];
      return it;
   endfunction

   function automatic req_type random_item();
      req_type it;
      int pick;
      it   = req_type'($urandom);
      pick = $urandom_range(99);
      if (pick < 48) begin
         it.func   = FUNC_WRITE;
         it.column = ($urandom_range(99) < 85) ? 5'($urandom_range(0, 11))
                                               : 5'($urandom_range(0, 31));
         pick      = $urandom_range(99);
         if (pick < 80) it.char_code = 8'($urandom_range(33, 126));
         else if (pick < 88) it.char_code = 8'd0;
      end else if (pick < 50) begin
         it.func = FUNC_CLEAR;
      end else if (pick < 95) begin
         it.func = FUNC_RENDER;
         if ($urandom_range(99) < 85) it.row = 8'($urandom_range(0, WIDTH - 1));
      end else begin
         it.func = FUNC_NONE;
      end
      return it;
   endfunction

   // Present one beat, hold it until taken, then update the prediction.
   task automatic send_beat(req_type it, bit all_white);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid   <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
      apply_item(it, all_white);
   endtask

   // Drop valid and wait out every expected byte plus a drain margin.
   task automatic settle(int extra);
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         REG_ROTATION:    shadow_cfg.rotation    = value[1:0];
         REG_MARGIN_TOP:  shadow_cfg.margin_top  = value[4:0];
         REG_MARGIN_LEFT: shadow_cfg.margin_left = value[7:0];
         default: ;
      endcase
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic add_step(logic [1:0] f, int ln, int cl, int ch, int rw, bit all_white);
      script_items.push_back(make_item(f, ln, cl, ch, rw));
      script_white.push_back(all_white);
   endtask

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = rsp_payload;
         if (expected_bytes.size() == 0) begin
            note_mismatch("beat with nothing expected", int'(got), 0);
         end else begin
            want = expected_bytes.pop_front();
            if (got.pixel_byte != want.pixel_byte)
               note_mismatch("pixel_byte", int'(got.pixel_byte), int'(want.pixel_byte));
            if (got.byte_index != want.byte_index)
               note_mismatch("byte_index", int'(got.byte_index), int'(want.byte_index));
            if (got.last != want.last)
               note_mismatch("last", int'(got.last), int'(want.last));
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   initial begin
      int rot_set [8] = '{1, 2, 3, 0, 1, 2, 3, 0};
      int top_set [8] = '{0, 24, 31, 0, 12, 5, 3, 24};
      int left_set [8] = '{0, 199, 255, 0, 100, 4, 20, 199};
      int n;
      req_type it;

      foreach (shadow_text[i, j]) shadow_text[i][j] = 8'd0;
      shadow_cfg.rotation    = RESET_ROTATION;
      shadow_cfg.margin_top  = RESET_MARGIN_TOP;
      shadow_cfg.margin_left = RESET_MARGIN_LEFT;

      add_step(FUNC_RENDER, 0, 0, 0, 0, 1'b1);
      add_step(FUNC_RENDER, 7, 31, 255, 199, 1'b1);
      add_step(FUNC_WRITE, 0, 0, 65, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 1, 32, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 2, 127, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 3, 31, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 4, 255, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 5, 128, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 6, 87, 255, 1'b0);
      add_step(FUNC_WRITE, 0, 30, 35, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 31, 64, 0, 1'b0);
      add_step(FUNC_WRITE, 7, 0, 56, 0, 1'b0);
      add_step(FUNC_RENDER, 0, 0, 0, 5, 1'b0);
      add_step(FUNC_RENDER, 0, 0, 0, 12, 1'b0);
      add_step(FUNC_RENDER, 0, 0, 0, 200, 1'b1);
      add_step(FUNC_RENDER, 0, 0, 0, 255, 1'b1);
      add_step(FUNC_NONE, 7, 31, 255, 255, 1'b0);
      for (int c = 7; c < 30; c++) add_step(FUNC_WRITE, 1, c, 90, 0, 1'b0);
      add_step(FUNC_WRITE, 0, 7, 90, 0, 1'b0);
      add_step(FUNC_RENDER, 0, 0, 0, 18, 1'b0);
      add_step(FUNC_RENDER, 0, 0, 0, 180, 1'b0);
      add_step(FUNC_CLEAR, 0, 0, 0, 0, 1'b0);
      add_step(FUNC_RENDER, 0, 0, 0, 5, 1'b1);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script_items[i]) send_beat(script_items[i], script_white[i]);

      for (int p = 0; p < 8; p++) begin
         settle(DRAIN_WAIT);
         case (p % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 84;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 84;
            end
            default: begin
               send_idle_pct = 18;
               stall_pct     = 18;
            end
         endcase
         write_reg(REG_ROTATION, rot_set[p]);
         write_reg(REG_MARGIN_TOP, top_set[p]);
         write_reg(REG_MARGIN_LEFT, left_set[p]);
         n = 0;
         while (n < 46) begin
            it = random_item();
            send_beat(it, 1'b0);
            n++;
            if (p == 2 && n == 23) settle(0);
         end
      end

      settle(DRAIN_WAIT);
      if (mismatches == 0)
         $display("PASS text_mode_row_renderer_unit");
      else
         $display("FAIL text_mode_row_renderer_unit");
      $finish;
   end

endmodule

`default_nettype wire
